### rtl/sch_pkg.sv
package sch_pkg;

	// field widths
	localparam int COORD_W = 24;
	localparam int RAD_W   = COORD_W - 1;

	// arithmetic widths
	localparam int DIFF_W  = COORD_W + 1;       // coordinate differences
	localparam int PROD_W  = 2 * DIFF_W;        // one signed product
	localparam int DOT_W   = PROD_W + 2;        // sum of three products
	localparam int RSUM_W  = COORD_W;           // radius sum
	localparam int R2_W    = 2 * RSUM_W;        // squared radius sum
	localparam int CROSS_W = PROD_W + 1;        // cross product component
	localparam int HALF_W  = DIFF_W;            // partial product operand
	localparam int MAG_W   = 2 * HALF_W;        // magnitude of a cross component
	localparam int PP_W    = 2 * HALF_W;        // one partial product
	localparam int WIDE_W  = 2 * MAG_W + 4;     // exact squared terms and their sums

	// dot products, cross product and squared radius sum after the vector stages
	typedef struct packed {
		logic signed [DOT_W-1:0]   len2;
		logic signed [DOT_W-1:0]   tn;
		logic signed [DOT_W-1:0]   w2;
		logic signed [DOT_W-1:0]   e2;
		logic signed [CROSS_W-1:0] cx;
		logic signed [CROSS_W-1:0] cy;
		logic signed [CROSS_W-1:0] cz;
		logic [R2_W-1:0]           r2;
	} sch_dot_t;

	// nearest-point decision
	typedef struct packed {
		logic inner;    // projection strictly inside the segment
		logic end_hit;  // result when an end point is nearest
	} sch_sel_t;

	// exact wide terms for the inner case
	typedef struct packed {
		logic [WIDE_W-1:0] sq_x;
		logic [WIDE_W-1:0] sq_y;
		logic [WIDE_W-1:0] sq_z;
		logic [WIDE_W-1:0] rhs;
		sch_sel_t          sel;
	} sch_sq_t;

endpackage

### rtl/sch_dot_unit.sv
module sch_dot_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic signed [sch_pkg::COORD_W-1:0]  sphere_x,
	input  logic signed [sch_pkg::COORD_W-1:0]  sphere_y,
	input  logic signed [sch_pkg::COORD_W-1:0]  sphere_z,
	input  logic [sch_pkg::RAD_W-1:0]           sphere_radius,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_a_x,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_a_y,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_a_z,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_b_x,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_b_y,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_b_z,
	input  logic [sch_pkg::RAD_W-1:0]           cap_radius,
	output logic                                vld_s3,
	output sch_pkg::sch_dot_t                   dot_s3
);

	localparam int DW  = sch_pkg::DIFF_W;
	localparam int DTW = sch_pkg::DOT_W;
	localparam int CW  = sch_pkg::CROSS_W;
	localparam int RW  = sch_pkg::RSUM_W;

	// stage 1: axis, sphere-from-A and sphere-from-B vectors, radius sum
	logic                          vld_s1;
	logic signed [DW-1:0]          dx_s1, dy_s1, dz_s1;
	logic signed [DW-1:0]          wx_s1, wy_s1, wz_s1;
	logic signed [DW-1:0]          ex_s1, ey_s1, ez_s1;
	logic [RW-1:0]                 rsum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= DW'(cap_b_x) - DW'(cap_a_x);
		dy_s1   <= DW'(cap_b_y) - DW'(cap_a_y);
		dz_s1   <= DW'(cap_b_z) - DW'(cap_a_z);
		wx_s1   <= DW'(sphere_x) - DW'(cap_a_x);
		wy_s1   <= DW'(sphere_y) - DW'(cap_a_y);
		wz_s1   <= DW'(sphere_z) - DW'(cap_a_z);
		ex_s1   <= DW'(sphere_x) - DW'(cap_b_x);
		ey_s1   <= DW'(sphere_y) - DW'(cap_b_y);
		ez_s1   <= DW'(sphere_z) - DW'(cap_b_z);
		rsum_s1 <= RW'(sphere_radius) + RW'(cap_radius);
	end

	// stage 2: all element products, one multiplier each
	logic                                  vld_s2;
	logic signed [sch_pkg::PROD_W-1:0]     ddx_s2, ddy_s2, ddz_s2;
	logic signed [sch_pkg::PROD_W-1:0]     dwx_s2, dwy_s2, dwz_s2;
	logic signed [sch_pkg::PROD_W-1:0]     wwx_s2, wwy_s2, wwz_s2;
	logic signed [sch_pkg::PROD_W-1:0]     eex_s2, eey_s2, eez_s2;
	logic signed [sch_pkg::PROD_W-1:0]     wydz_s2, wzdy_s2, wzdx_s2;
	logic signed [sch_pkg::PROD_W-1:0]     wxdz_s2, wxdy_s2, wydx_s2;
	logic [sch_pkg::R2_W-1:0]              r2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ddx_s2  <= dx_s1 * dx_s1;
		ddy_s2  <= dy_s1 * dy_s1;
		ddz_s2  <= dz_s1 * dz_s1;
		dwx_s2  <= dx_s1 * wx_s1;
		dwy_s2  <= dy_s1 * wy_s1;
		dwz_s2  <= dz_s1 * wz_s1;
		wwx_s2  <= wx_s1 * wx_s1;
		wwy_s2  <= wy_s1 * wy_s1;
		wwz_s2  <= wz_s1 * wz_s1;
		eex_s2  <= ex_s1 * ex_s1;
		eey_s2  <= ey_s1 * ey_s1;
		eez_s2  <= ez_s1 * ez_s1;
		wydz_s2 <= wy_s1 * dz_s1;
		wzdy_s2 <= wz_s1 * dy_s1;
		wzdx_s2 <= wz_s1 * dx_s1;
		wxdz_s2 <= wx_s1 * dz_s1;
		wxdy_s2 <= wx_s1 * dy_s1;
		wydx_s2 <= wy_s1 * dx_s1;
		r2_s2   <= rsum_s1 * rsum_s1;
	end

	// stage 3: dot product sums and cross product w x d
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		dot_s3.len2 <= DTW'(ddx_s2) + DTW'(ddy_s2) + DTW'(ddz_s2);
		dot_s3.tn   <= DTW'(dwx_s2) + DTW'(dwy_s2) + DTW'(dwz_s2);
		dot_s3.w2   <= DTW'(wwx_s2) + DTW'(wwy_s2) + DTW'(wwz_s2);
		dot_s3.e2   <= DTW'(eex_s2) + DTW'(eey_s2) + DTW'(eez_s2);
		dot_s3.cx   <= CW'(wydz_s2) - CW'(wzdy_s2);
		dot_s3.cy   <= CW'(wzdx_s2) - CW'(wxdz_s2);
		dot_s3.cz   <= CW'(wxdy_s2) - CW'(wydx_s2);
		dot_s3.r2   <= r2_s2;
	end

endmodule

### rtl/sch_wide_unit.sv
module sch_wide_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_s3,
	input  sch_pkg::sch_dot_t  dot_s3,
	output logic               vld_s6,
	output sch_pkg::sch_sq_t   sq_s6
);

	localparam int DTW = sch_pkg::DOT_W;
	localparam int MW  = sch_pkg::MAG_W;
	localparam int HW  = sch_pkg::HALF_W;
	localparam int WW  = sch_pkg::WIDE_W;

	// nearest-point decision from the dot products
	logic signed [DTW-1:0] r2_sx;
	logic                  len_zero, tn_nonpos, tn_past_b, w_lt, e_lt;
	sch_pkg::sch_sel_t     sel;

	always_comb begin
		r2_sx     = $signed(DTW'(dot_s3.r2));
		len_zero  = (dot_s3.len2 == '0);
		tn_nonpos = (dot_s3.tn <= 0);
		tn_past_b = (dot_s3.tn >= dot_s3.len2);
		w_lt      = (dot_s3.w2 < r2_sx);
		e_lt      = (dot_s3.e2 < r2_sx);
		sel.inner   = 1'b0;
		sel.end_hit = w_lt;
		if (len_zero || tn_nonpos) begin
			sel.end_hit = w_lt;
		end else if (tn_past_b) begin
			sel.end_hit = e_lt;
		end else begin
			sel.inner = 1'b1;
		end
	end

	// stage 4: magnitudes of the cross components, decision
	logic              vld_s4;
	logic [MW-1:0]     mx_s4, my_s4, mz_s4, r2_s4, len2_s4;
	sch_pkg::sch_sel_t sel_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		mx_s4   <= dot_s3.cx[sch_pkg::CROSS_W-1] ? MW'(-dot_s3.cx) : MW'(dot_s3.cx);
		my_s4   <= dot_s3.cy[sch_pkg::CROSS_W-1] ? MW'(-dot_s3.cy) : MW'(dot_s3.cy);
		mz_s4   <= dot_s3.cz[sch_pkg::CROSS_W-1] ? MW'(-dot_s3.cz) : MW'(dot_s3.cz);
		r2_s4   <= MW'(dot_s3.r2);
		len2_s4 <= MW'(dot_s3.len2);
		sel_s4  <= sel;
	end

	// stage 5: half-width partial products
	logic                      vld_s5;
	logic [sch_pkg::PP_W-1:0]  xhh_s5, xhl_s5, xll_s5;
	logic [sch_pkg::PP_W-1:0]  yhh_s5, yhl_s5, yll_s5;
	logic [sch_pkg::PP_W-1:0]  zhh_s5, zhl_s5, zll_s5;
	logic [sch_pkg::PP_W-1:0]  rhh_s5, rhl_s5, rlh_s5, rll_s5;
	sch_pkg::sch_sel_t         sel_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		xhh_s5 <= mx_s4[MW-1:HW] * mx_s4[MW-1:HW];
		xhl_s5 <= mx_s4[MW-1:HW] * mx_s4[HW-1:0];
		xll_s5 <= mx_s4[HW-1:0]  * mx_s4[HW-1:0];
		yhh_s5 <= my_s4[MW-1:HW] * my_s4[MW-1:HW];
		yhl_s5 <= my_s4[MW-1:HW] * my_s4[HW-1:0];
		yll_s5 <= my_s4[HW-1:0]  * my_s4[HW-1:0];
		zhh_s5 <= mz_s4[MW-1:HW] * mz_s4[MW-1:HW];
		zhl_s5 <= mz_s4[MW-1:HW] * mz_s4[HW-1:0];
		zll_s5 <= mz_s4[HW-1:0]  * mz_s4[HW-1:0];
		rhh_s5 <= r2_s4[MW-1:HW] * len2_s4[MW-1:HW];
		rhl_s5 <= r2_s4[MW-1:HW] * len2_s4[HW-1:0];
		rlh_s5 <= r2_s4[HW-1:0]  * len2_s4[MW-1:HW];
		rll_s5 <= r2_s4[HW-1:0]  * len2_s4[HW-1:0];
		sel_s5 <= sel_s4;
	end

	// stage 6: exact squares of the cross components and r2 * len2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		sq_s6.sq_x <= (WW'(xhh_s5) << (2 * HW)) + (WW'(xhl_s5) << (HW + 1)) + WW'(xll_s5);
		sq_s6.sq_y <= (WW'(yhh_s5) << (2 * HW)) + (WW'(yhl_s5) << (HW + 1)) + WW'(yll_s5);
		sq_s6.sq_z <= (WW'(zhh_s5) << (2 * HW)) + (WW'(zhl_s5) << (HW + 1)) + WW'(zll_s5);
		sq_s6.rhs  <= (WW'(rhh_s5) << (2 * HW)) + ((WW'(rhl_s5) + WW'(rlh_s5)) << HW)
			+ WW'(rll_s5);
		sq_s6.sel  <= sel_s5;
	end

	// a cross component stays below 2^49 in magnitude, so its square below 2^98
	a_sq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> (sq_s6.sq_x[WW-1:2*MW-2] == '0) && (sq_s6.sq_y[WW-1:2*MW-2] == '0)
			&& (sq_s6.sq_z[WW-1:2*MW-2] == '0))
		else $error("cross component square out of range");

endmodule

### rtl/sphere_capsule_hit_test.sv
// sphere against capsule overlap test, one query per transaction
// done is raised from the result register once the query has passed all stages
// throughput: one query every cycle; busy is held low
// the receiver cannot stall: each result is shown for exactly one cycle
// reset (arst_n low) clears all stage valid bits; in-flight queries are dropped
module sphere_capsule_hit_test (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [sch_pkg::COORD_W-1:0]  sphere_x,
	input  logic signed [sch_pkg::COORD_W-1:0]  sphere_y,
	input  logic signed [sch_pkg::COORD_W-1:0]  sphere_z,
	input  logic [sch_pkg::RAD_W-1:0]           sphere_radius,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_a_x,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_a_y,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_a_z,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_b_x,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_b_y,
	input  logic signed [sch_pkg::COORD_W-1:0]  cap_b_z,
	input  logic [sch_pkg::RAD_W-1:0]           cap_radius,
	output logic                                done,
	output logic                                hit
);

	// the pipeline never holds, so a query is always taken
	assign busy = 1'b0;

	logic              vld_s3, vld_s6;
	sch_pkg::sch_dot_t dot_s3;
	sch_pkg::sch_sq_t  sq_s6;

	// stages 1 to 3: vectors, products, dot and cross products
	sch_dot_unit u_dot (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (start && !busy),
		.sphere_x      (sphere_x),
		.sphere_y      (sphere_y),
		.sphere_z      (sphere_z),
		.sphere_radius (sphere_radius),
		.cap_a_x       (cap_a_x),
		.cap_a_y       (cap_a_y),
		.cap_a_z       (cap_a_z),
		.cap_b_x       (cap_b_x),
		.cap_b_y       (cap_b_y),
		.cap_b_z       (cap_b_z),
		.cap_radius    (cap_radius),
		.vld_s3        (vld_s3),
		.dot_s3        (dot_s3)
	);

	// stages 4 to 6: decision and exact wide squares
	sch_wide_unit u_wide (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s3 (vld_s3),
		.dot_s3 (dot_s3),
		.vld_s6 (vld_s6),
		.sq_s6  (sq_s6)
	);

	// inner case: |w x d|^2 < r2 * len2, i.e. squared distance times len2
	logic [sch_pkg::WIDE_W-1:0] lhs;
	logic                       hit_d;

	always_comb begin
		lhs   = sq_s6.sq_x + sq_s6.sq_y + sq_s6.sq_z;
		hit_d = sq_s6.sel.inner ? (lhs < sq_s6.rhs) : sq_s6.sel.end_hit;
	end

	// stage 7: result register
	logic vld_s7;
	logic hit_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		hit_s7 <= hit_d;
	end

	assign done = vld_s7;
	assign hit  = hit_s7;

	// every result comes from an earlier transaction
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 7))
		else $error("result without a matching transaction");

	// every transaction gives its result
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 done)
		else $error("transaction lost in the pipeline");

endmodule

### tb/sv/sphere_capsule_hit_test_check.sv
`timescale 1ns / 1ps

module sphere_capsule_hit_test_check (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic signed [sch_pkg::COORD_W-1:0] sphere_x,
	input  logic signed [sch_pkg::COORD_W-1:0] sphere_y,
	input  logic signed [sch_pkg::COORD_W-1:0] sphere_z,
	input  logic [sch_pkg::RAD_W-1:0]          sphere_radius,
	input  logic signed [sch_pkg::COORD_W-1:0] cap_a_x,
	input  logic signed [sch_pkg::COORD_W-1:0] cap_a_y,
	input  logic signed [sch_pkg::COORD_W-1:0] cap_a_z,
	input  logic signed [sch_pkg::COORD_W-1:0] cap_b_x,
	input  logic signed [sch_pkg::COORD_W-1:0] cap_b_y,
	input  logic signed [sch_pkg::COORD_W-1:0] cap_b_z,
	input  logic [sch_pkg::RAD_W-1:0]          cap_radius,
	input  logic                               done,
	input  logic                               hit,
	output int                                 failures,
	output int                                 pending_hits
);

	typedef logic signed [127:0] wide_t;
	typedef logic [2:0][sch_pkg::COORD_W-1:0] vec_t;

	// hit flags still owed by the block, oldest first
	bit hit_queue[$];

	// exact overlap decision, squared terms only, no division
	function automatic bit overlap_of(input vec_t s, input logic [sch_pkg::RAD_W-1:0] rs,
			input vec_t a, input vec_t b, input logic [sch_pkg::RAD_W-1:0] rc);
		wide_t d[3];
		wide_t w[3];
		wide_t e[3];
		wide_t len2, tn, w2, e2, rsum, r2;
		for (int i = 0; i < 3; i++) begin
			d[i] = wide_t'($signed(b[i])) - wide_t'($signed(a[i]));
			w[i] = wide_t'($signed(s[i])) - wide_t'($signed(a[i]));
			e[i] = wide_t'($signed(s[i])) - wide_t'($signed(b[i]));
		end
		len2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
		tn   = d[0] * w[0] + d[1] * w[1] + d[2] * w[2];
		w2   = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
		e2   = e[0] * e[0] + e[1] * e[1] + e[2] * e[2];
		rsum = wide_t'(rs) + wide_t'(rc);
		r2   = rsum * rsum;
		// nearest point is A: degenerate axis or projection at or behind A
		if (len2 == 0 || tn <= 0)
			return w2 < r2;
		// nearest point is B: projection at or past B
		if (tn >= len2)
			return e2 < r2;
		// projection strictly inside, scaled through by len2
		return (w2 * len2 - tn * tn) < r2 * len2;
	endfunction

	// compare results first, then record the transaction taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (hit_queue.size() == 0) begin
					$error("hit: expected none, actual %0b", hit);
					failures++;
				end else if (hit !== hit_queue[0]) begin
					$error("hit: expected %0b, actual %0b", hit_queue[0], hit);
					failures++;
					void'(hit_queue.pop_front());
				end else begin
					void'(hit_queue.pop_front());
				end
			end
			if (start && !busy)
				hit_queue.insert(hit_queue.size(), overlap_of({sphere_z, sphere_y, sphere_x},
					sphere_radius, {cap_a_z, cap_a_y, cap_a_x}, {cap_b_z, cap_b_y, cap_b_x},
					cap_radius));
			pending_hits = hit_queue.size();
		end
	end

endmodule

### tb/sv/sphere_capsule_hit_test_test.sv
`timescale 1ns / 1ps

module sphere_capsule_hit_test_test;

	localparam int COORD_W   = sch_pkg::COORD_W;
	localparam int RAD_W     = sch_pkg::RAD_W;
	localparam int N_QUERIES = 1600;
	localparam int CALM_TAIL = 200;
	localparam int LIMIT     = 100000;
	localparam int C_MAX     = 8388607;
	localparam int C_MIN     = -8388608;

	typedef struct packed {
		logic [2:0][COORD_W-1:0] s;
		logic [RAD_W-1:0]        rs;
		logic [2:0][COORD_W-1:0] a;
		logic [2:0][COORD_W-1:0] b;
		logic [RAD_W-1:0]        rc;
	} query_t;

	logic clk, arst_n, start, busy, done, hit;
	logic signed [COORD_W-1:0] sphere_x, sphere_y, sphere_z;
	logic signed [COORD_W-1:0] cap_a_x, cap_a_y, cap_a_z;
	logic signed [COORD_W-1:0] cap_b_x, cap_b_y, cap_b_z;
	logic [RAD_W-1:0] sphere_radius, cap_radius;
	logic taken;
	int failures, pending_hits, cycle_count;
	bit calm;

	sphere_capsule_hit_test uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sphere_x(sphere_x), .sphere_y(sphere_y), .sphere_z(sphere_z),
		.sphere_radius(sphere_radius),
		.cap_a_x(cap_a_x), .cap_a_y(cap_a_y), .cap_a_z(cap_a_z),
		.cap_b_x(cap_b_x), .cap_b_y(cap_b_y), .cap_b_z(cap_b_z),
		.cap_radius(cap_radius), .done(done), .hit(hit)
	);

	sphere_capsule_hit_test_check checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sphere_x(sphere_x), .sphere_y(sphere_y), .sphere_z(sphere_z),
		.sphere_radius(sphere_radius),
		.cap_a_x(cap_a_x), .cap_a_y(cap_a_y), .cap_a_z(cap_a_z),
		.cap_b_x(cap_b_x), .cap_b_y(cap_b_y), .cap_b_z(cap_b_z),
		.cap_radius(cap_radius), .done(done), .hit(hit),
		.failures(failures), .pending_hits(pending_hits)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// transaction taken at the last rising edge
	always @(posedge clk) taken <= start && !busy;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("** sphere_capsule_hit_test: FAILED **");
			$finish;
		end
	end

	function automatic query_t make_query(int sx, int sy, int sz, int rs,
			int ax, int ay, int az, int bx, int by, int bz, int rc);
		query_t q;
		q.s  = {sz[COORD_W-1:0], sy[COORD_W-1:0], sx[COORD_W-1:0]};
		q.a  = {az[COORD_W-1:0], ay[COORD_W-1:0], ax[COORD_W-1:0]};
		q.b  = {bz[COORD_W-1:0], by[COORD_W-1:0], bx[COORD_W-1:0]};
		q.rs = RAD_W'(rs);
		q.rc = RAD_W'(rc);
		return q;
	endfunction

	function automatic logic [COORD_W-1:0] extreme_coord();
		case ($urandom_range(0, 4))
			0: return COORD_W'(C_MIN);
			1: return COORD_W'(C_MAX);
			2: return '0;
			3: return '1;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic logic [RAD_W-1:0] extreme_radius();
		case ($urandom_range(0, 2))
			0: return '0;
			1: return RAD_W'(C_MAX);
			default: return RAD_W'($urandom);
		endcase
	endfunction

	// mix of plain noise, local clusters, exact contact geometry and extremes
	function automatic query_t random_query();
		query_t q;
		int k, j, len, h, rsum, span, base;
		q = query_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom});
		case ($urandom_range(0, 9))
			3, 4, 5, 6: begin
				// nearby shapes, radii on the scale of the spread
				span = 1 << $urandom_range(2, 14);
				for (int i = 0; i < 3; i++) begin
					base   = $urandom_range(0, 1 << 22) - (1 << 21);
					q.a[i] = COORD_W'(base + $urandom_range(0, 2 * span) - span);
					q.b[i] = COORD_W'(base + $urandom_range(0, 2 * span) - span);
					q.s[i] = COORD_W'(base + $urandom_range(0, 2 * span) - span);
				end
				q.rs = RAD_W'($urandom_range(0, span));
				q.rc = RAD_W'($urandom_range(0, span));
				// degenerate axis now and then
				if ($urandom_range(0, 3) == 0)
					q.b = q.a;
			end
			7, 8: begin
				// axis along one coordinate, sphere at a known distance
				k = $urandom_range(0, 2);
				j = (k + 1) % 3;
				for (int i = 0; i < 3; i++)
					q.a[i] = COORD_W'($urandom_range(0, 1 << 21) - (1 << 20));
				q.b    = q.a;
				len    = $urandom_range(1, 4000);
				q.b[k] = COORD_W'(q.a[k] + len);
				h      = $urandom_range(0, 3000);
				q.s    = q.a;
				case ($urandom_range(0, 3))
					0: q.s[k] = COORD_W'(q.a[k] - h);
					1: begin
						q.s    = q.b;
						q.s[k] = COORD_W'(q.b[k] + h);
					end
					2: begin
						q.s[k] = COORD_W'(q.a[k] + $urandom_range(0, len));
						q.s[j] = COORD_W'(q.a[j] + h);
					end
					default: begin
						q.s    = q.b;
						q.s[j] = COORD_W'(q.b[j] - h);
					end
				endcase
				// radius sum just below, at, or just above the distance
				rsum = h + $urandom_range(0, 2) - 1;
				if (rsum < 0)
					rsum = 0;
				q.rs = RAD_W'($urandom_range(0, rsum));
				q.rc = RAD_W'(rsum - q.rs);
			end
			9: begin
				for (int i = 0; i < 3; i++) begin
					q.s[i] = extreme_coord();
					q.a[i] = extreme_coord();
					q.b[i] = extreme_coord();
				end
				q.rs = extreme_radius();
				q.rc = extreme_radius();
			end
			default: ;
		endcase
		return q;
	endfunction

	// drive one query and hold it until the block takes it
	task automatic send_query(input query_t q);
		start         <= 1'b1;
		sphere_x      <= q.s[0];
		sphere_y      <= q.s[1];
		sphere_z      <= q.s[2];
		sphere_radius <= q.rs;
		cap_a_x       <= q.a[0];
		cap_a_y       <= q.a[1];
		cap_a_z       <= q.a[2];
		cap_b_x       <= q.b[0];
		cap_b_y       <= q.b[1];
		cap_b_z       <= q.b[2];
		cap_radius    <= q.rc;
		do @(negedge clk); while (!taken);
	endtask

	// idle burst with junk on the payload
	task automatic idle_for(input int n);
		start    <= 1'b0;
		sphere_x <= COORD_W'($urandom);
		cap_b_z  <= COORD_W'($urandom);
		repeat (n) @(negedge clk);
	endtask

	// hold off until every outstanding hit flag has come back
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (pending_hits != 0);
	endtask

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		sphere_x      = '0;
		sphere_y      = '0;
		sphere_z      = '0;
		sphere_radius = '0;
		cap_a_x       = '0;
		cap_a_y       = '0;
		cap_a_z       = '0;
		cap_b_x       = '0;
		cap_b_y       = '0;
		cap_b_z       = '0;
		cap_radius    = '0;
		calm          = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// everything zero, and a zero radius sum with the sphere on A
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(5, 0, 0, 0, 5, 0, 0, 9, 0, 0, 0));
		// zero-length axis, inside then touching
		send_query(make_query(3, 0, 0, 2, 0, 0, 0, 0, 0, 0, 2));
		send_query(make_query(3, 0, 0, 1, 0, 0, 0, 0, 0, 0, 2));
		// projection exactly at A
		send_query(make_query(0, 50, 0, 25, 0, 0, 0, 100, 0, 0, 26));
		send_query(make_query(0, 50, 0, 25, 0, 0, 0, 100, 0, 0, 25));
		// projection exactly at B
		send_query(make_query(100, 50, 0, 50, 0, 0, 0, 100, 0, 0, 0));
		send_query(make_query(100, 50, 0, 50, 0, 0, 0, 100, 0, 0, 1));
		// projection inside the segment, touching then overlapping
		send_query(make_query(40, 30, 0, 15, 0, 0, 0, 100, 0, 0, 15));
		send_query(make_query(40, 30, 0, 15, 0, 0, 0, 100, 0, 0, 16));
		// past B and behind A, touching then overlapping
		send_query(make_query(130, 40, 0, 0, 0, 0, 0, 100, 0, 0, 50));
		send_query(make_query(130, 40, 0, 0, 0, 0, 0, 100, 0, 0, 51));
		send_query(make_query(-30, -40, 0, 50, 0, 0, 0, 100, 0, 0, 0));
		send_query(make_query(-30, -40, 0, 50, 0, 0, 0, 100, 0, 0, 1));
		// sphere centre on a diagonal axis
		send_query(make_query(-100, -100, -100, 0, 0, 0, 0, -200, -200, -200, 1));
		// field extremes
		send_query(make_query(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
			C_MIN, C_MIN, C_MIN, C_MAX));
		send_query(make_query(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX,
			C_MIN, C_MAX, C_MIN, C_MAX));
		send_query(make_query(C_MAX, C_MIN, C_MAX, 0, C_MIN, C_MAX, C_MIN,
			C_MAX, C_MIN, C_MAX, 0));
		send_query(make_query(0, 0, 0, C_MAX, C_MIN, 0, 0, C_MAX, 0, 0, C_MAX));
		drain();

		// random queries, idle bursts except in calm stretches and the tail
		for (int n = 0; n < N_QUERIES; n++) begin
			if (n % 150 == 0)
				calm = $urandom_range(0, 2) == 0;
			send_query(random_query());
			if (n == N_QUERIES / 2)
				drain();
			else if (n < N_QUERIES - CALM_TAIL && !calm && $urandom_range(0, 3) == 0)
				idle_for($urandom_range(1, 5));
		end
		start <= 1'b0;

		// wait out the pipeline, then a margin for stray results
		while (pending_hits != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (failures == 0)
			$display("** sphere_capsule_hit_test: PASSED **");
		else
			$display("** sphere_capsule_hit_test: FAILED **");
		$finish;
	end

endmodule
